// ----- rtl/pisbc_pkg.sv -----
// Package with shared constants and types for the PI setpoint bias controller.
`default_nettype none
package pisbc_pkg;

    // Status codes of a result word.
    typedef enum logic [2:0] {
        STAT_NO_TARGET  = 3'd0,
        STAT_NO_READING = 3'd1,
        STAT_HOLDING    = 3'd2,
        STAT_LIMITED    = 3'd3,
        STAT_COMMANDED  = 3'd4
    } status_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] REG_DEADBAND     = 3'd2;
    localparam logic [2:0] REG_BIAS_LIMIT   = 3'd3;
    localparam logic [2:0] REG_INTEG_LIMIT  = 3'd4;
    localparam logic [2:0] REG_SP_MIN       = 3'd5;
    localparam logic [2:0] REG_SP_MAX       = 3'd6;
    localparam logic [2:0] REG_CMD_GAP      = 3'd7;

    localparam int CFG_WIDTH = 39;

    // Integration scaling: increment = (|err| * dt * 4096 + 1875) / 3750.
    localparam logic [12:0] DIV_CONST  = 13'd3750;
    localparam logic [11:0] DIV_ROUND  = 12'd1875;
    localparam logic [31:0] DEFAULT_DT = 32'd60000;
    localparam logic [15:0] TARGET_TOL = 16'd12;

    // Step counts of the serial units, loaded as count minus one.
    localparam logic [5:0] DT_MUL_LAST   = 6'd31;
    localparam logic [5:0] GAIN_MUL_LAST = 6'd15;
    localparam logic [5:0] DIV_LAST      = 6'd60;

endpackage
`default_nettype wire

// ----- rtl/pi_setpoint_bias_controller.sv -----
// PI setpoint bias controller: serial shift-add multiplier and restoring divider.
// Without a target or reading the word goes straight to the output state. Otherwise the
// bit-serial multiplier (32 steps, then 16 and 16), the 61-step divider and 3 finish steps
// run; inside the deadband the dt product and the divider are skipped.
// The next word is taken in the cycle after the result enters the output register; a full
// output register stalls it. Reset (sync, active low) loads defaults.
`default_nettype none
module pi_setpoint_bias_controller
    import pisbc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_restart,
    input  wire logic                 s_target_valid,
    input  wire logic signed [15:0]   s_target_temp,
    input  wire logic                 s_temp_valid,
    input  wire logic signed [15:0]   s_measured_temp,
    input  wire logic [31:0]          s_now_ms,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [2:0]                m_status_code,
    output logic                      m_engage,
    output logic                      m_power_off,
    output logic [5:0]                m_setpoint,
    output logic signed [15:0]        m_bias,
    output logic signed [15:0]        m_error
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_DT, ST_DIV, ST_INTEG, ST_MUL_I, ST_MUL_P,
        ST_FIN1, ST_FIN2, ST_FIN3, ST_OUT
    } state_t;

    // Configuration registers.
    logic [15:0] prop_gain_reg, integ_gain_reg;
    logic [14:0] deadband_reg, bias_limit_reg;
    logic [38:0] integ_limit_reg;
    logic [5:0]  sp_min_reg, sp_max_reg;
    logic [31:0] cmd_gap_reg;

    // Loop state.
    logic               engaged_reg, engaged_next;
    logic signed [15:0] last_target_reg, last_target_next;
    logic               ltk_reg, ltk_next;
    logic signed [40:0] integ_reg, integ_next;
    logic [31:0]        last_eval_reg, last_eval_next;
    logic [31:0]        last_cmd_reg, last_cmd_next;
    logic               has_cmd_reg, has_cmd_next;
    logic [5:0]         cmd_sp_reg, cmd_sp_next;

    // Working registers of one evaluation.
    state_t             state_reg, state_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [16:0] err_reg, err_next;
    logic [31:0]        now_reg, now_next;
    logic               start_reg, start_next;
    logic signed [63:0] mul_m_reg, mul_m_next;
    logic [31:0]        mul_b_reg, mul_b_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [60:0]        div_n_reg, div_n_next;
    logic [11:0]        div_r_reg, div_r_next;
    logic [39:0]        rb_reg, rb_next;
    logic               neg_reg, neg_next;
    logic [5:0]         desired_reg, desired_next;

    // Result being assembled, then the output register.
    logic [2:0]         res_status_reg, res_status_next;
    logic               res_engage_reg, res_engage_next;
    logic               res_poff_reg, res_poff_next;
    logic [5:0]         res_sp_reg, res_sp_next;
    logic signed [15:0] res_bias_reg, res_bias_next;
    logic signed [15:0] res_err_reg, res_err_next;
    logic               m_valid_reg, m_valid_next;
    logic [2:0]         m_status_reg, m_status_next;
    logic               m_engage_reg, m_engage_next;
    logic               m_poff_reg, m_poff_next;
    logic [5:0]         m_sp_reg, m_sp_next;
    logic signed [15:0] m_bias_reg, m_bias_next;
    logic signed [15:0] m_err_reg, m_err_next;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status_code = m_status_reg;
    assign m_engage      = m_engage_reg;
    assign m_power_off   = m_poff_reg;
    assign m_setpoint    = m_sp_reg;
    assign m_bias        = m_bias_reg;
    assign m_error       = m_err_reg;

    // Next-state logic of the sequencer and its datapath.
    always_comb begin
        logic               ltk_e, eng_e, chg, start;
        logic [31:0]        let_e;
        logic signed [16:0] tdiff, err;
        logic [16:0]        tmag, emag;
        logic signed [63:0] prod_step, sum, lim;
        logic [12:0]        rtry;
        logic [63:0]        tm;
        logic [14:0]        rbc;
        logic signed [15:0] bias;
        logic signed [17:0] s;
        logic [17:0]        smag;
        logic signed [11:0] des;
        logic               same, limited;

        ltk_e   = 1'b0;
        eng_e   = 1'b0;
        chg     = 1'b0;
        start   = 1'b0;
        let_e   = '0;
        tdiff   = '0;
        err     = '0;
        tmag    = '0;
        emag    = '0;
        sum     = '0;
        lim     = '0;
        rtry    = '0;
        tm      = '0;
        rbc     = '0;
        bias    = '0;
        s       = '0;
        smag    = '0;
        des     = '0;
        same    = 1'b0;
        limited = 1'b0;

        state_next       = state_reg;
        engaged_next     = engaged_reg;
        last_target_next = last_target_reg;
        ltk_next         = ltk_reg;
        integ_next       = integ_reg;
        last_eval_next   = last_eval_reg;
        last_cmd_next    = last_cmd_reg;
        has_cmd_next     = has_cmd_reg;
        cmd_sp_next      = cmd_sp_reg;
        target_next      = target_reg;
        err_next         = err_reg;
        now_next         = now_reg;
        start_next       = start_reg;
        mul_m_next       = mul_m_reg;
        mul_b_next       = mul_b_reg;
        prod_next        = prod_reg;
        cnt_next         = cnt_reg;
        div_n_next       = div_n_reg;
        div_r_next       = div_r_reg;
        rb_next          = rb_reg;
        neg_next         = neg_reg;
        desired_next     = desired_reg;
        res_status_next  = res_status_reg;
        res_engage_next  = res_engage_reg;
        res_poff_next    = res_poff_reg;
        res_sp_next      = res_sp_reg;
        res_bias_next    = res_bias_reg;
        res_err_next     = res_err_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_engage_next    = m_engage_reg;
        m_poff_next      = m_poff_reg;
        m_sp_next        = m_sp_reg;
        m_bias_next      = m_bias_reg;
        m_err_next       = m_err_reg;

        // One shift-add step of the serial multiplier.
        prod_step = mul_b_reg[0] ? prod_reg + mul_m_reg : prod_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ltk_e = ltk_reg;
                    eng_e = engaged_reg;
                    let_e = last_eval_reg;
                    res_status_next = STAT_NO_TARGET;
                    res_engage_next = 1'b0;
                    res_poff_next   = 1'b0;
                    res_sp_next     = '0;
                    res_bias_next   = '0;
                    res_err_next    = '0;
                    // A restart clears the loop before anything else.
                    if (s_restart) begin
                        integ_next   = '0;
                        has_cmd_next = 1'b0;
                        cmd_sp_next  = '0;
                        ltk_e        = 1'b0;
                        let_e        = '0;
                    end
                    ltk_next       = ltk_e;
                    last_eval_next = let_e;
                    if (!s_target_valid) begin
                        if (eng_e) begin
                            res_poff_next = 1'b1;
                            engaged_next  = 1'b0;
                            integ_next    = '0;
                            has_cmd_next  = 1'b0;
                            cmd_sp_next   = '0;
                            ltk_next      = 1'b0;
                        end
                        state_next = ST_OUT;
                    end else if (!s_temp_valid) begin
                        res_status_next = STAT_NO_READING;
                        state_next      = ST_OUT;
                    end else begin
                        tdiff = 17'(last_target_reg) - 17'(s_target_temp);
                        tmag  = tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
                        chg   = !ltk_e || (tmag > {1'b0, TARGET_TOL});
                        start = !eng_e || chg;
                        if (start) begin
                            integ_next       = '0;
                            has_cmd_next     = 1'b0;
                            cmd_sp_next      = '0;
                            let_e            = s_now_ms;
                            last_target_next = s_target_temp;
                            ltk_next         = 1'b1;
                            engaged_next     = 1'b1;
                            res_engage_next  = 1'b1;
                        end
                        last_eval_next = s_now_ms;
                        err  = 17'(s_target_temp) - 17'(s_measured_temp);
                        emag = err[16] ? 17'(-err) : 17'(err);
                        err_next    = err;
                        target_next = s_target_temp;
                        now_next    = s_now_ms;
                        start_next  = start;
                        prod_next   = '0;
                        if (emag > {2'b00, deadband_reg}) begin
                            mul_m_next = 64'(emag);
                            mul_b_next = (let_e == '0) ? DEFAULT_DT : s_now_ms - let_e;
                            cnt_next   = DT_MUL_LAST;
                            state_next = ST_MUL_DT;
                        end else begin
                            // Integral stays; the bias product starts at once.
                            mul_m_next = 64'(integ_next);
                            mul_b_next = 32'(integ_gain_reg);
                            cnt_next   = GAIN_MUL_LAST;
                            state_next = ST_MUL_I;
                        end
                    end
                end
            end

            // Error magnitude times elapsed milliseconds, one bit of dt a cycle.
            ST_MUL_DT: begin
                prod_next  = prod_step;
                mul_m_next = mul_m_reg <<< 1;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    div_n_next = {prod_step[48:0], DIV_ROUND};
                    div_r_next = '0;
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end

            // Restoring division by the per-minute constant, one quotient bit a cycle.
            ST_DIV: begin
                rtry = {div_r_reg, div_n_reg[60]};
                if (rtry >= DIV_CONST) begin
                    div_r_next = 12'(rtry - DIV_CONST);
                    div_n_next = {div_n_reg[59:0], 1'b1};
                end else begin
                    div_r_next = rtry[11:0];
                    div_n_next = {div_n_reg[59:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_INTEG;
                end
            end

            // Signed integral update with clamp to the limit.
            ST_INTEG: begin
                lim = 64'(integ_limit_reg);
                sum = err_reg[16] ? 64'(integ_reg) - 64'(div_n_reg)
                                  : 64'(integ_reg) + 64'(div_n_reg);
                if (sum > lim) begin
                    sum = lim;
                end
                if (sum < -lim) begin
                    sum = -lim;
                end
                integ_next = 41'(sum);
                mul_m_next = 64'(41'(sum));
                mul_b_next = 32'(integ_gain_reg);
                prod_next  = '0;
                cnt_next   = GAIN_MUL_LAST;
                state_next = ST_MUL_I;
            end

            // Integral gain times integral.
            ST_MUL_I: begin
                prod_next  = prod_step;
                mul_m_next = mul_m_reg <<< 1;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    mul_m_next = 64'(err_reg) <<< 16;
                    mul_b_next = 32'(prop_gain_reg);
                    cnt_next   = GAIN_MUL_LAST;
                    state_next = ST_MUL_P;
                end
            end

            // Proportional term added onto the same sum.
            ST_MUL_P: begin
                prod_next  = prod_step;
                mul_m_next = mul_m_reg <<< 1;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN1;
                end
            end

            // Round the sum magnitude to Q8.8.
            ST_FIN1: begin
                tm = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
                tm = tm + 64'h0000_0000_0080_0000;
                rb_next    = tm[63:24];
                neg_next   = prod_reg[63];
                state_next = ST_FIN2;
            end

            // Clamp the bias, round target plus bias, clamp to the unit range.
            ST_FIN2: begin
                rbc  = (rb_reg > 40'(bias_limit_reg)) ? bias_limit_reg : rb_reg[14:0];
                bias = neg_reg ? -16'(rbc) : 16'(rbc);
                s    = 18'(target_reg) + 18'(bias);
                smag = s[17] ? 18'(-s) : 18'(s);
                smag = smag + 18'd128;
                des  = s[17] ? -12'(smag[17:8]) : 12'(smag[17:8]);
                if (des < $signed({6'd0, sp_min_reg})) begin
                    des = $signed({6'd0, sp_min_reg});
                end
                if (des > $signed({6'd0, sp_max_reg})) begin
                    des = $signed({6'd0, sp_max_reg});
                end
                desired_next  = des[5:0];
                res_sp_next   = des[5:0];
                res_bias_next = bias;
                if (err_reg > 17'sd32767) begin
                    res_err_next = 16'sh7FFF;
                end else if (err_reg < -17'sd32768) begin
                    res_err_next = 16'sh8000;
                end else begin
                    res_err_next = err_reg[15:0];
                end
                state_next = ST_FIN3;
            end

            // Hold, rate limit or command.
            ST_FIN3: begin
                same    = has_cmd_reg && (desired_reg == cmd_sp_reg);
                limited = (last_cmd_reg != '0) && ((now_reg - last_cmd_reg) < cmd_gap_reg);
                if (same) begin
                    res_status_next = STAT_HOLDING;
                end else if (limited && !start_reg) begin
                    res_status_next = STAT_LIMITED;
                end else begin
                    res_status_next = STAT_COMMANDED;
                    cmd_sp_next     = desired_reg;
                    has_cmd_next    = 1'b1;
                    last_cmd_next   = now_reg;
                end
                state_next = ST_OUT;
            end

            // Move the result word into the output register once it is free.
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_engage_next = res_engage_reg;
                    m_poff_next   = res_poff_reg;
                    m_sp_next     = res_sp_reg;
                    m_bias_next   = res_bias_reg;
                    m_err_next    = res_err_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            prop_gain_reg   <= 16'd256;
            integ_gain_reg  <= 16'd64;
            deadband_reg    <= 15'd51;
            bias_limit_reg  <= 15'd768;
            integ_limit_reg <= 39'd201326592;
            sp_min_reg      <= 6'd16;
            sp_max_reg      <= 6'd30;
            cmd_gap_reg     <= 32'd300000;
            engaged_reg     <= 1'b0;
            last_target_reg <= '0;
            ltk_reg         <= 1'b0;
            integ_reg       <= '0;
            last_eval_reg   <= '0;
            last_cmd_reg    <= '0;
            has_cmd_reg     <= 1'b0;
            cmd_sp_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            engaged_reg     <= engaged_next;
            last_target_reg <= last_target_next;
            ltk_reg         <= ltk_next;
            integ_reg       <= integ_next;
            last_eval_reg   <= last_eval_next;
            last_cmd_reg    <= last_cmd_next;
            has_cmd_reg     <= has_cmd_next;
            cmd_sp_reg      <= cmd_sp_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[15:0];
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[15:0];
                    REG_DEADBAND:    deadband_reg    <= cfg_wdata[14:0];
                    REG_BIAS_LIMIT:  bias_limit_reg  <= cfg_wdata[14:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[38:0];
                    REG_SP_MIN:      sp_min_reg      <= cfg_wdata[5:0];
                    REG_SP_MAX:      sp_max_reg      <= cfg_wdata[5:0];
                    REG_CMD_GAP:     cmd_gap_reg     <= cfg_wdata[31:0];
                    default: ;
                endcase
            end
        end
        target_reg     <= target_next;
        err_reg        <= err_next;
        now_reg        <= now_next;
        start_reg      <= start_next;
        mul_m_reg      <= mul_m_next;
        mul_b_reg      <= mul_b_next;
        prod_reg       <= prod_next;
        cnt_reg        <= cnt_next;
        div_n_reg      <= div_n_next;
        div_r_reg      <= div_r_next;
        rb_reg         <= rb_next;
        neg_reg        <= neg_next;
        desired_reg    <= desired_next;
        res_status_reg <= res_status_next;
        res_engage_reg <= res_engage_next;
        res_poff_reg   <= res_poff_next;
        res_sp_reg     <= res_sp_next;
        res_bias_reg   <= res_bias_next;
        res_err_reg    <= res_err_next;
        m_status_reg   <= m_status_next;
        m_engage_reg   <= m_engage_next;
        m_poff_reg     <= m_poff_next;
        m_sp_reg       <= m_sp_next;
        m_bias_reg     <= m_bias_next;
        m_err_reg      <= m_err_next;
    end

`ifndef SYNTHESIS
    // An accepted word keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a word");

    // An engage request only comes with a computed setpoint.
    a_engage_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_engage |-> (m_status_code == STAT_HOLDING ||
                                 m_status_code == STAT_LIMITED ||
                                 m_status_code == STAT_COMMANDED))
        else $error("engage without a setpoint result");

    // Power off only for a missing target.
    a_poff_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_power_off |-> m_status_code == STAT_NO_TARGET && !m_engage)
        else $error("power off with a wrong status");

    // A commanded setpoint never exceeds the upper range limit.
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status_code == STAT_COMMANDED |-> m_setpoint <= sp_max_reg)
        else $error("setpoint above the upper limit");
`endif

endmodule
`default_nettype wire
